// ===== design/c2ss_pkg.sv =====
// Package with the month tables and constants for the calendar to second stamp converter.
package c2ss_pkg;

  localparam logic [13:0] MAX_YEAR      = 14'd9999;
  localparam logic [12:0] RECIP_100     = 13'd5243;
  localparam int          RECIP_SHIFT   = 19;
  localparam logic [6:0]  CENTURY       = 7'd100;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [31:0] EPOCH_DAY_NUM = 32'd730119;
  localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
  localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
  localparam logic [5:0]  SEC_PER_MIN   = 6'd60;

  // Length of month m (1 to 12); zero for a month number that means nothing.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the year before the first of month m.
  function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    logic [8:0] extra;
    extra = {8'd0, leap};
    case (m)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (m > 4'd2) begin
      base = base + extra;
    end
    return base;
  endfunction

endpackage

// ===== design/calendar_to_second_stamp.sv =====
// Top level of the calendar date and time to second stamp converter.
//
// One input beat carries a Gregorian date (year, month, day of month) and a
// time of day. One output beat carries the signed count of seconds since
// 1999-12-31 00:00 and a flag that says whether the date was valid. Invalid
// dates (year outside 1 to 9999, month outside 1 to 12, or a day that is not
// in that month) give a stamp of zero and a cleared flag. The time of day is
// not checked. The stamp wraps modulo 2^32.
//
// The block is a five stage pipeline: range checks and divide-by-100, leap
// year and day-of-year table, day number, the multiply by 86400, and the
// final add in the output register. out_valid rises once the beat has passed
// through every stage register; while the receiver does not stall, one beat
// is accepted every cycle. The multiply by 86400 sets the depth of the
// critical stage.
//
// Reset clears every stage's valid bit, so the pipeline comes up empty.
// When the receiver stalls, the stages fill up from the output backward;
// each stage holds its beat until the next stage frees, and in_ready falls
// only once every stage holds a beat. Nothing is dropped or repeated.
module calendar_to_second_stamp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [13:0]        in_year,
  input  logic [3:0]         in_month,
  input  logic [4:0]         in_day_of_month,
  input  logic [4:0]         in_hour,
  input  logic [5:0]         in_minute,
  input  logic [5:0]         in_second,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_second_stamp,
  output logic               out_date_valid
);
  import c2ss_pkg::*;

  // Stage valid bits and advance enables. A stage may load when it is empty
  // or when its current beat moves on in the same cycle.
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic s1_en, s2_en, s3_en, s4_en, s5_en;

  assign s5_en    = !s5_v_r || out_ready;
  assign s4_en    = !s4_v_r || s5_en;
  assign s3_en    = !s3_v_r || s4_en;
  assign s2_en    = !s2_v_r || s3_en;
  assign s1_en    = !s1_v_r || s2_en;
  assign in_ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      if (s1_en) s1_v_r <= in_valid;
      if (s2_en) s2_v_r <= s1_v_r;
      if (s3_en) s3_v_r <= s2_v_r;
      if (s4_en) s4_v_r <= s3_v_r;
      if (s5_en) s5_v_r <= s4_v_r;
    end
  end

  // Stage 1: year and month range checks, and year / 100 for both the year
  // and the year before it, by a multiply with the scaled reciprocal.
  logic [13:0] p_nxt;
  logic [26:0] qy_prod, qp_prod;
  logic        range_ok_nxt;

  logic [13:0] s1_y_r, s1_p_r;
  logic [3:0]  s1_m_r;
  logic [4:0]  s1_d_r, s1_hh_r;
  logic [5:0]  s1_mm_r, s1_ss_r;
  logic [7:0]  s1_qy_r, s1_qp_r;
  logic        s1_ok_r;

  assign p_nxt        = in_year - 14'd1;
  assign qy_prod      = {13'd0, in_year} * {14'd0, RECIP_100};
  assign qp_prod      = {13'd0, p_nxt} * {14'd0, RECIP_100};
  assign range_ok_nxt = (in_year != 14'd0) && (in_year <= MAX_YEAR) &&
                        (in_month != 4'd0) && (in_month <= 4'd12);

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_y_r  <= in_year;
      s1_p_r  <= p_nxt;
      s1_m_r  <= in_month;
      s1_d_r  <= in_day_of_month;
      s1_hh_r <= in_hour;
      s1_mm_r <= in_minute;
      s1_ss_r <= in_second;
      s1_qy_r <= qy_prod[RECIP_SHIFT +: 8];
      s1_qp_r <= qp_prod[RECIP_SHIFT +: 8];
      s1_ok_r <= range_ok_nxt;
    end
  end

  // Stage 2: leap year rule, month table, day check, and the pieces of the
  // day number: years times 365 and the leap day correction.
  logic        leap;
  logic [14:0] cent_y;
  logic [4:0]  mlen;
  logic [8:0]  dbefore;
  logic [22:0] p365_nxt;
  logic [11:0] corr_nxt;

  logic [22:0] s2_p365_r;
  logic [11:0] s2_corr_r;
  logic [8:0]  s2_doy_r;
  logic [4:0]  s2_hh_r;
  logic [5:0]  s2_mm_r, s2_ss_r;
  logic        s2_ok_r;

  assign cent_y   = {7'd0, s1_qy_r} * {8'd0, CENTURY};
  assign leap     = (s1_y_r[1:0] == 2'b00) &&
                    ((cent_y != {1'b0, s1_y_r}) || (s1_qy_r[1:0] == 2'b00));
  assign mlen     = month_len(s1_m_r, leap);
  assign dbefore  = days_before(s1_m_r, leap);
  assign p365_nxt = {9'd0, s1_p_r} * {14'd0, DAYS_PER_YEAR};
  assign corr_nxt = s1_p_r[13:2] - {4'd0, s1_qp_r} + {6'd0, s1_qp_r[7:2]};

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_p365_r <= p365_nxt;
      s2_corr_r <= corr_nxt;
      s2_doy_r  <= dbefore + {4'd0, s1_d_r};
      s2_hh_r   <= s1_hh_r;
      s2_mm_r   <= s1_mm_r;
      s2_ss_r   <= s1_ss_r;
      s2_ok_r   <= s1_ok_r && (s1_d_r != 5'd0) && (s1_d_r <= mlen);
    end
  end

  // Stage 3: day number and the distance in days from the epoch day.
  logic [31:0] s3_days_r;
  logic [4:0]  s3_hh_r;
  logic [5:0]  s3_mm_r, s3_ss_r;
  logic        s3_ok_r;

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_days_r <= {9'd0, s2_p365_r} + {20'd0, s2_corr_r} + {23'd0, s2_doy_r}
                   - EPOCH_DAY_NUM;
      s3_hh_r   <= s2_hh_r;
      s3_mm_r   <= s2_mm_r;
      s3_ss_r   <= s2_ss_r;
      s3_ok_r   <= s2_ok_r;
    end
  end

  // Stage 4: days times 86400, kept to 32 bits, and the seconds of the day.
  logic [48:0] day_sec;
  logic [16:0] hh_sec, mm_sec, tod_nxt;

  logic [31:0] s4_prod_r;
  logic [16:0] s4_tod_r;
  logic        s4_ok_r;

  assign day_sec = {17'd0, s3_days_r} * {32'd0, SEC_PER_DAY};
  assign hh_sec  = 17'({12'd0, s3_hh_r} * {5'd0, SEC_PER_HOUR});
  assign mm_sec  = 17'({6'd0, s3_mm_r} * {6'd0, SEC_PER_MIN});
  assign tod_nxt = hh_sec + mm_sec + {11'd0, s3_ss_r};

  always_ff @(posedge clk) begin
    if (s4_en) begin
      s4_prod_r <= day_sec[31:0];
      s4_tod_r  <= tod_nxt;
      s4_ok_r   <= s3_ok_r;
    end
  end

  // Stage 5: output register. An invalid date is forced to zero here.
  logic [31:0] s5_stamp_r;
  logic        s5_ok_r;

  always_ff @(posedge clk) begin
    if (s5_en) begin
      s5_stamp_r <= s4_ok_r ? (s4_prod_r + {15'd0, s4_tod_r}) : 32'd0;
      s5_ok_r    <= s4_ok_r;
    end
  end

  assign out_valid        = s5_v_r;
  assign out_second_stamp = signed'(s5_stamp_r);
  assign out_date_valid   = s5_ok_r;

endmodule
